// ----- hw/rtl/mmcc_pkg.sv -----
// Package: check mode codes, CRC constants, result type and per-byte code functions.
`default_nettype none

package mmcc_pkg;

  localparam int unsigned ModeWidth = 3;

  localparam logic [ModeWidth-1:0] MODE_CRC16    = 3'd0;
  localparam logic [ModeWidth-1:0] MODE_CHECKSUM = 3'd1;
  localparam logic [ModeWidth-1:0] MODE_EVEN_PAR = 3'd2;
  localparam logic [ModeWidth-1:0] MODE_ODD_PAR  = 3'd3;
  localparam logic [ModeWidth-1:0] MODE_2D_PAR   = 3'd4;
  localparam logic [ModeWidth-1:0] MODE_HAMMING  = 3'd5;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [3:0]  NIBBLE_MASK = 4'hF;

  typedef logic [ModeWidth-1:0] mode_t;

  typedef struct packed {
    logic [6:0]  high_codeword;
    logic [6:0]  low_codeword;
    logic        row_parity;
    logic [15:0] check_value;
    logic        check_valid;
  } result_t;

  // Bytewise CRC-16/CCITT-FALSE update, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Ones'-complement add with end-around carry folded.
  function automatic logic [15:0] ones_add(input logic [15:0] sum, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, sum} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Codeword bits 6..0 = p1 p2 d0 p3 d1 d2 d3, d0 the nibble MSB.
  function automatic logic [6:0] hamming74(input logic [3:0] nib);
    logic d0, d1, d2, d3;
    d0 = nib[3];
    d1 = nib[2];
    d2 = nib[1];
    d3 = nib[0];
    return {d0 ^ d1 ^ d3, d0 ^ d2 ^ d3, d0, d1 ^ d2 ^ d3, d1, d2, d3};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mmcc_if.sv -----
// Interfaces: message byte channel and result channel with valid/ready handshake.
`default_nettype none

interface mmcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mmcc_result_if;
  logic        valid;
  logic        ready;
  logic [6:0]  high_codeword;
  logic [6:0]  low_codeword;
  logic        row_parity;
  logic [15:0] check_value;
  logic        check_valid;

  modport source (output valid, output high_codeword, output low_codeword, output row_parity,
                  output check_value, output check_valid, input ready);
  modport sink   (input valid, input high_codeword, input low_codeword, input row_parity,
                  input check_value, input check_valid, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/multi_mode_check_code_engine.sv -----
// Top level: CRC-16, internet checksum, parity, 2D parity and Hamming(7,4) engine.
//
//   channel   dir  handshake      payload
//   msg       in   valid/ready    data_byte[7:0], last_byte
//   result    out  valid/ready    high_codeword, low_codeword, row_parity,
//                                 check_value[15:0], check_valid
//   cfg       in   cfg_write      cfg_data[2:0] -> check_mode
//
// One byte per cycle sustained while result.ready holds; a request passes an input
// register and then a result register. The message accumulators update as a byte
// leaves the input register. Reset sets check_mode to crc16 and clears both stages.
// A stalled result holds; the input register still takes one more request behind it.
`default_nettype none

module multi_mode_check_code_engine (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire mmcc_pkg::mode_t       cfg_data,
  mmcc_byte_if.sink                  msg,
  mmcc_result_if.source              result
);
  import mmcc_pkg::*;

  mode_t       check_mode;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;

  logic        out_valid;
  result_t     out_data;
  result_t     out_data_next;

  logic [15:0] crc_accum;
  logic [15:0] sum_accum;
  logic        ones_parity;
  logic [7:0]  column_parity;
  logic [7:0]  pending_high_byte;
  logic        half_pair;

  logic [15:0] crc_next;
  logic [15:0] sum_next;
  logic        ones_parity_next;
  logic [7:0]  column_parity_next;
  logic [7:0]  pending_next;
  logic        half_pair_next;
  logic        rowp;

  logic        out_ready;
  logic        advance;

  assign out_ready = !out_valid || result.ready;
  assign advance   = in_valid && out_ready;
  assign msg.ready = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode <= MODE_CRC16;
    end else if (cfg_write) begin
      check_mode <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (msg.ready) begin
      in_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      in_byte <= msg.data_byte;
      in_last <= msg.last_byte;
    end
  end

  always_comb begin
    rowp               = ^in_byte;
    crc_next           = crc_byte(crc_accum, in_byte);
    ones_parity_next   = ones_parity ^ rowp;
    column_parity_next = column_parity ^ in_byte;
    sum_next           = sum_accum;
    pending_next       = pending_high_byte;
    half_pair_next     = half_pair;
    if (half_pair) begin
      sum_next       = ones_add(sum_accum, {pending_high_byte, in_byte});
      pending_next   = 8'h00;
      half_pair_next = 1'b0;
    end else if (in_last) begin
      // pad the odd final byte with zero
      sum_next = ones_add(sum_accum, {in_byte, 8'h00});
    end else begin
      pending_next   = in_byte;
      half_pair_next = 1'b1;
    end
  end

  always_comb begin
    out_data_next.high_codeword = hamming74(in_byte[7:4] & NIBBLE_MASK);
    out_data_next.low_codeword  = hamming74(in_byte[3:0] & NIBBLE_MASK);
    out_data_next.row_parity    = rowp;
    out_data_next.check_value   = 16'h0000;
    out_data_next.check_valid   = 1'b0;
    if (in_last) begin
      out_data_next.check_valid = 1'b1;
      unique case (check_mode)
        MODE_CRC16:    out_data_next.check_value = crc_next;
        MODE_CHECKSUM: out_data_next.check_value = ~sum_next;
        MODE_EVEN_PAR: out_data_next.check_value = {15'd0, ones_parity_next};
        MODE_ODD_PAR:  out_data_next.check_value = {15'd0, ~ones_parity_next};
        MODE_2D_PAR:   out_data_next.check_value = {8'h00, column_parity_next};
        default:       out_data_next.check_valid = 1'b0;
      endcase
    end
  end

  // Message accumulators: advance on each byte, restart after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum         <= CRC_INIT;
      sum_accum         <= 16'h0000;
      ones_parity       <= 1'b0;
      column_parity     <= 8'h00;
      pending_high_byte <= 8'h00;
      half_pair         <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        crc_accum         <= CRC_INIT;
        sum_accum         <= 16'h0000;
        ones_parity       <= 1'b0;
        column_parity     <= 8'h00;
        pending_high_byte <= 8'h00;
        half_pair         <= 1'b0;
      end else begin
        crc_accum         <= crc_next;
        sum_accum         <= sum_next;
        ones_parity       <= ones_parity_next;
        column_parity     <= column_parity_next;
        pending_high_byte <= pending_next;
        half_pair         <= half_pair_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.high_codeword = out_data.high_codeword;
  assign result.low_codeword  = out_data.low_codeword;
  assign result.row_parity    = out_data.row_parity;
  assign result.check_value   = out_data.check_value;
  assign result.check_valid   = out_data.check_valid;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for the multi-mode check code engine: directed table, random messages, scoreboard.
`default_nettype none

module testbench;
  import mmcc_pkg::*;

  localparam mode_t MODE_SPARE_6 = 3'd6;
  localparam mode_t MODE_SPARE_7 = 3'd7;
  localparam int NUM_DIRECTED = 22;
  localparam int ITEMS_PER_PHASE = 209;
  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD = 60;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    mode_t      mode;
    logic       typed;
    result_t    want;
  } vector_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  cfg_write;
  mode_t cfg_data;

  mmcc_byte_if   msg_ch ();
  mmcc_result_if res_ch ();

  multi_mode_check_code_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .msg       (msg_ch),
    .result    (res_ch)
  );

  always #1 clk = ~clk;

  // Predictor state
  mode_t       active_mode;
  logic [15:0] crc_reg;
  logic [15:0] sum_reg;
  logic        parity_reg;
  logic [7:0]  column_reg;
  logic [7:0]  pend_reg;
  logic        half_reg;

  result_t expected_codes [$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      src_idle_pct = 0;
  int      sink_idle_pct = 0;
  logic    hold_armed = 1'b0;
  logic    hold_done = 1'b0;
  int      stall_cycles = 0;

  vector_t directed_rows [NUM_DIRECTED] = '{
    '{8'h00, 1'b1, MODE_CRC16,    1'b0, result_t'(0)},
    '{8'hFF, 1'b1, MODE_CRC16,    1'b0, result_t'(0)},
    '{8'h31, 1'b0, MODE_CRC16,    1'b0, result_t'(0)},
    '{8'h32, 1'b1, MODE_CRC16,    1'b0, result_t'(0)},
    '{8'h00, 1'b1, MODE_CHECKSUM, 1'b1, '{7'h00, 7'h00, 1'b0, 16'hFFFF, 1'b1}},
    '{8'hFF, 1'b1, MODE_CHECKSUM, 1'b1, '{7'h7F, 7'h7F, 1'b0, 16'h00FF, 1'b1}},
    '{8'hFF, 1'b0, MODE_CHECKSUM, 1'b1, '{7'h7F, 7'h7F, 1'b0, 16'h0000, 1'b0}},
    '{8'hFF, 1'b1, MODE_CHECKSUM, 1'b1, '{7'h7F, 7'h7F, 1'b0, 16'h0000, 1'b1}},
    '{8'h12, 1'b0, MODE_CHECKSUM, 1'b0, result_t'(0)},
    '{8'h34, 1'b0, MODE_CHECKSUM, 1'b0, result_t'(0)},
    '{8'h56, 1'b1, MODE_CHECKSUM, 1'b0, result_t'(0)},
    '{8'hFF, 1'b1, MODE_EVEN_PAR, 1'b1, '{7'h7F, 7'h7F, 1'b0, 16'h0000, 1'b1}},
    '{8'h01, 1'b1, MODE_ODD_PAR,  1'b1, '{7'h00, 7'h69, 1'b1, 16'h0000, 1'b1}},
    '{8'hA5, 1'b1, MODE_2D_PAR,   1'b1, '{7'h5A, 7'h25, 1'b0, 16'h00A5, 1'b1}},
    '{8'hFF, 1'b0, MODE_2D_PAR,   1'b0, result_t'(0)},
    '{8'h0F, 1'b1, MODE_2D_PAR,   1'b0, result_t'(0)},
    '{8'hF0, 1'b1, MODE_HAMMING,  1'b1, '{7'h7F, 7'h00, 1'b0, 16'h0000, 1'b0}},
    '{8'h0F, 1'b1, MODE_SPARE_6,  1'b0, result_t'(0)},
    // message started in one mode, finished in another
    '{8'h80, 1'b0, MODE_SPARE_7,  1'b0, result_t'(0)},
    '{8'h01, 1'b1, MODE_CRC16,    1'b0, result_t'(0)},
    '{8'h80, 1'b0, MODE_EVEN_PAR, 1'b0, result_t'(0)},
    '{8'h01, 1'b1, MODE_EVEN_PAR, 1'b0, result_t'(0)}
  };

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = a + w;
    if (s[16]) begin
      s = {1'b0, s[15:0]} + 17'd1;
    end
    return s[15:0];
  endfunction

  function automatic logic [6:0] hamming_code(input logic [3:0] n);
    logic [6:0] cw;
    cw[4] = n[3];
    cw[2] = n[2];
    cw[1] = n[1];
    cw[0] = n[0];
    cw[6] = cw[4] ^ cw[2] ^ cw[0];
    cw[5] = cw[4] ^ cw[1] ^ cw[0];
    cw[3] = cw[2] ^ cw[1] ^ cw[0];
    return cw;
  endfunction

  task automatic clear_codes();
    crc_reg = CRC_INIT;
    sum_reg = '0;
    parity_reg = 1'b0;
    column_reg = '0;
    pend_reg = '0;
    half_reg = 1'b0;
  endtask

  task automatic advance_codes(input logic [7:0] b, input logic last, output result_t r);
    logic rowp;
    rowp = ^b;
    crc_reg = crc_update(crc_reg, b);
    parity_reg = parity_reg ^ rowp;
    column_reg = column_reg ^ b;
    if (half_reg) begin
      sum_reg = fold_add(sum_reg, {pend_reg, b});
      half_reg = 1'b0;
      pend_reg = '0;
    end else if (last) begin
      sum_reg = fold_add(sum_reg, {b, 8'h00});
    end else begin
      pend_reg = b;
      half_reg = 1'b1;
    end
    r.high_codeword = hamming_code(b[7:4]);
    r.low_codeword = hamming_code(b[3:0] & NIBBLE_MASK);
    r.row_parity = rowp;
    r.check_value = '0;
    r.check_valid = 1'b0;
    if (last) begin
      r.check_valid = 1'b1;
      case (active_mode)
        MODE_CRC16:    r.check_value = crc_reg;
        MODE_CHECKSUM: r.check_value = ~sum_reg;
        MODE_EVEN_PAR: r.check_value = {15'd0, parity_reg};
        MODE_ODD_PAR:  r.check_value = {15'd0, ~parity_reg};
        MODE_2D_PAR:   r.check_value = {8'd0, column_reg};
        default:       r.check_valid = 1'b0;
      endcase
      clear_codes();
    end
  endtask

  // Offer one request, wait for it to be taken, then record what it should produce.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input result_t want);
    result_t r;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.data_byte <= b;
    msg_ch.last_byte <= last;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    advance_codes(b, last, r);
    expected_codes.push_back(typed ? want : r);
    items_sent++;
  endtask

  // Drop valid and wait until every result is out and the pipeline is empty.
  task automatic drain_engine();
    @(negedge clk);
    msg_ch.valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_check_mode(input mode_t m);
    drain_engine();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_write <= 1'b0;
    active_mode = m;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_message();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(19) == 0) begin
        set_check_mode(mode_t'($urandom_range(7)));
      end
      send_byte(pick_byte(), i == len - 1, 1'b0, result_t'(0));
    end
  endtask

  // Receiver: random ready, plus one long hold-off while the sender keeps going
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (res_ch.valid && res_ch.ready) begin
      if (expected_codes.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        want = expected_codes.pop_front();
        if (res_ch.high_codeword !== want.high_codeword) begin
          $error("high_codeword expected %h got %h", want.high_codeword,
                 res_ch.high_codeword);
          mismatch_count++;
        end
        if (res_ch.low_codeword !== want.low_codeword) begin
          $error("low_codeword expected %h got %h", want.low_codeword, res_ch.low_codeword);
          mismatch_count++;
        end
        if (res_ch.row_parity !== want.row_parity) begin
          $error("row_parity expected %b got %b", want.row_parity, res_ch.row_parity);
          mismatch_count++;
        end
        if (res_ch.check_value !== want.check_value) begin
          $error("check_value expected %h got %h", want.check_value, res_ch.check_value);
          mismatch_count++;
        end
        if (res_ch.check_valid !== want.check_valid) begin
          $error("check_valid expected %b got %b", want.check_valid, res_ch.check_valid);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = MODE_CRC16;
    msg_ch.valid = 1'b0;
    msg_ch.data_byte = '0;
    msg_ch.last_byte = 1'b0;
    active_mode = MODE_CRC16;
    clear_codes();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].mode != active_mode) begin
        set_check_mode(directed_rows[i].mode);
      end
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 24;
          sink_idle_pct = 53;
          set_check_mode(MODE_SPARE_7);
        end
        1: begin
          src_idle_pct = 53;
          sink_idle_pct = 24;
          set_check_mode(MODE_CRC16);
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
          set_check_mode(MODE_CHECKSUM);
          hold_armed = 1'b1;
        end
      endcase
      while (items_sent < NUM_DIRECTED + (ph + 1) * ITEMS_PER_PHASE) begin
        if ($urandom_range(3) == 0) begin
          set_check_mode(mode_t'($urandom_range(7)));
        end
        send_message();
      end
    end

    drain_engine();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
